FILE: design/ptm_pkg.sv
// ptm_pkg: shared types and constants for the pose to transform matrix unit
// no dependencies; imported by every module of the block
`default_nettype none

package ptm_pkg;

   // fixed-point element types
   typedef logic signed [15:0] rot_type;    // Q1.14 rotation entry
   typedef logic signed [31:0] coord_type;  // Q15.16 coordinate
   typedef logic        [1:0]  row_type;

   // rows 0..2 of the emitted matrix
   localparam row_type RowFirst = 2'd0;
   localparam row_type RowLast  = 2'd2;

   // rotation clamp limits, Q1.14
   localparam int RotMax = 16384;
   localparam int RotMin = -16384;

   // rounding offset before the floor shift by 14
   localparam int RoundHalf = 8192;

   // depth of the queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      rot_type   quat_w;
      rot_type   quat_x;
      rot_type   quat_y;
      rot_type   quat_z;
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
      logic      invert;
   } req_type;

   typedef struct packed {
      row_type   row_index;
      rot_type   col0;
      rot_type   col1;
      rot_type   col2;
      coord_type translation;
      logic      last_row;
   } rsp_type;

   // classified pose handed from front to back: rot[row][col]
   typedef struct packed {
      rot_type   [2:0][2:0] rot;
      coord_type [2:0]      origin;
      logic                 invert;
   } pose_type;

endpackage

`default_nettype wire

FILE: design/ptm_front.sv
// ptm_front: accepts poses and builds the rounded, clamped 3x3 rotation matrix
// two stages: quaternion products, then entry sums with round and clamp; uses ptm_pkg
`default_nettype none

module ptm_front import ptm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output pose_type push_data
);

   typedef logic signed [31:0] prod_type;
   typedef logic signed [35:0] wide_type;

   localparam int PXx = 0;
   localparam int PYy = 1;
   localparam int PZz = 2;
   localparam int PXy = 3;
   localparam int PXz = 4;
   localparam int PYz = 5;
   localparam int PXw = 6;
   localparam int PYw = 7;
   localparam int PZw = 8;

   localparam wide_type RotOne = 36'sd268435456;  // 1.0 in Q2.28

   // stage a: products
   logic                 a_valid_ff, a_valid_in;
   prod_type [8:0]       prod_ff, prod_in;
   coord_type [2:0]      a_origin_ff;
   logic                 a_invert_ff;

   // stage b: matrix entries
   logic                 b_valid_ff, b_valid_in;
   pose_type             b_pose_ff, b_pose_in;

   logic                 a_adv;
   logic                 b_adv;

   function automatic wide_type ext(input prod_type p);
      return wide_type'(p);
   endfunction

   function automatic rot_type rot_entry(input wide_type v);
      wide_type            q;
      logic signed [21:0]  s;
      q = v + wide_type'(RoundHalf);
      s = $signed(q[35:14]);
      if (s > RotMax) begin
         return rot_type'(RotMax);
      end else if (s < RotMin) begin
         return rot_type'(RotMin);
      end
      return s[15:0];
   endfunction

   assign b_adv     = b_valid_ff && push_ready;
   assign a_adv     = a_valid_ff && (!b_valid_ff || b_adv);
   assign req_ready = !a_valid_ff || a_adv;

   always_comb begin
      prod_in[PXx] = prod_type'(req_data.quat_x) * prod_type'(req_data.quat_x);
      prod_in[PYy] = prod_type'(req_data.quat_y) * prod_type'(req_data.quat_y);
      prod_in[PZz] = prod_type'(req_data.quat_z) * prod_type'(req_data.quat_z);
      prod_in[PXy] = prod_type'(req_data.quat_x) * prod_type'(req_data.quat_y);
      prod_in[PXz] = prod_type'(req_data.quat_x) * prod_type'(req_data.quat_z);
      prod_in[PYz] = prod_type'(req_data.quat_y) * prod_type'(req_data.quat_z);
      prod_in[PXw] = prod_type'(req_data.quat_x) * prod_type'(req_data.quat_w);
      prod_in[PYw] = prod_type'(req_data.quat_y) * prod_type'(req_data.quat_w);
      prod_in[PZw] = prod_type'(req_data.quat_z) * prod_type'(req_data.quat_w);

      a_valid_in = a_valid_ff;
      if (req_ready) begin
         a_valid_in = req_valid;
      end

      b_valid_in = b_valid_ff;
      if (!b_valid_ff || b_adv) begin
         b_valid_in = a_valid_ff;
      end
   end

   always_comb begin
      b_pose_in.rot[0][0] = rot_entry(RotOne - ((ext(prod_ff[PYy]) + ext(prod_ff[PZz])) <<< 1));
      b_pose_in.rot[0][1] = rot_entry((ext(prod_ff[PXy]) - ext(prod_ff[PZw])) <<< 1);
      b_pose_in.rot[0][2] = rot_entry((ext(prod_ff[PXz]) + ext(prod_ff[PYw])) <<< 1);
      b_pose_in.rot[1][0] = rot_entry((ext(prod_ff[PXy]) + ext(prod_ff[PZw])) <<< 1);
      b_pose_in.rot[1][1] = rot_entry(RotOne - ((ext(prod_ff[PXx]) + ext(prod_ff[PZz])) <<< 1));
      b_pose_in.rot[1][2] = rot_entry((ext(prod_ff[PYz]) - ext(prod_ff[PXw])) <<< 1);
      b_pose_in.rot[2][0] = rot_entry((ext(prod_ff[PXz]) - ext(prod_ff[PYw])) <<< 1);
      b_pose_in.rot[2][1] = rot_entry((ext(prod_ff[PYz]) + ext(prod_ff[PXw])) <<< 1);
      b_pose_in.rot[2][2] = rot_entry(RotOne - ((ext(prod_ff[PXx]) + ext(prod_ff[PYy])) <<< 1));
      b_pose_in.origin    = a_origin_ff;
      b_pose_in.invert    = a_invert_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         prod_ff        <= prod_in;
         a_origin_ff[0] <= req_data.origin_x;
         a_origin_ff[1] <= req_data.origin_y;
         a_origin_ff[2] <= req_data.origin_z;
         a_invert_ff    <= req_data.invert;
      end
      if (!b_valid_ff || b_adv) begin
         b_pose_ff <= b_pose_in;
      end
   end

   assign push_valid = b_valid_ff;
   assign push_data  = b_pose_ff;

endmodule

`default_nettype wire

FILE: design/ptm_queue.sv
// ptm_queue: short register queue of classified poses between front and back
// depth from QueueDepth in ptm_pkg
`default_nettype none

module ptm_queue import ptm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  pose_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output pose_type pop_data
);

   pose_type               slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] p);
      if (p == QueuePtrW'(QueueDepth - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign push_ready = (count_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: design/ptm_back.sv
// ptm_back: walks the queued pose row by row and forms each result beat
// stage 1 selects the row and multiplies for the inverse translation, stage 2
// sums, rounds, clamps and holds the output register; uses ptm_pkg
`default_nettype none

module ptm_back import ptm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  pose_type pop_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   typedef logic signed [47:0] tprod_type;
   typedef logic signed [50:0] tacc_type;

   localparam logic signed [36:0] TransHi = 37'sd2147483647;
   localparam logic signed [36:0] TransLo = -37'sd2147483648;

   row_type               row_ff, row_in;

   logic                  s1_valid_ff, s1_valid_in;
   row_type               s1_row_ff;
   rot_type   [2:0]       s1_col_ff, s1_col_in;
   tprod_type [2:0]       s1_prod_ff, s1_prod_in;
   coord_type             s1_origin_ff;
   logic                  s1_invert_ff;

   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_data_ff, out_data_in;

   logic                  s2_ready;
   logic                  s1_ready;
   logic                  issue;

   tacc_type              acc;
   tacc_type              rnd;
   logic signed [36:0]    shifted;
   coord_type             t_inv;

   assign s2_ready  = !out_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign issue     = pop_valid && s1_ready;
   assign pop_ready = s1_ready && (row_ff == RowLast);

   // inverse takes column row_ff of R, direct takes row row_ff
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (pop_data.invert) begin
            s1_col_in[k] = pop_data.rot[k][row_ff];
         end else begin
            s1_col_in[k] = pop_data.rot[row_ff][k];
         end
         s1_prod_in[k] = tprod_type'($signed(s1_col_in[k]))
                         * tprod_type'($signed(pop_data.origin[k]));
      end
      row_in = row_ff;
      if (issue) begin
         row_in = (row_ff == RowLast) ? RowFirst : row_ff + 1'b1;
      end
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = pop_valid;
      end
   end

   // t = -(sum), rounded to Q15.16 and saturated
   always_comb begin
      acc     = tacc_type'(s1_prod_ff[0]) + tacc_type'(s1_prod_ff[1])
                + tacc_type'(s1_prod_ff[2]);
      rnd     = tacc_type'(RoundHalf) - acc;
      shifted = $signed(rnd[50:14]);
      if (shifted > TransHi) begin
         t_inv = coord_type'(TransHi);
      end else if (shifted < TransLo) begin
         t_inv = coord_type'(TransLo);
      end else begin
         t_inv = shifted[31:0];
      end

      out_data_in.row_index   = s1_row_ff;
      out_data_in.col0        = s1_col_ff[0];
      out_data_in.col1        = s1_col_ff[1];
      out_data_in.col2        = s1_col_ff[2];
      out_data_in.translation = s1_invert_ff ? t_inv : s1_origin_ff;
      out_data_in.last_row    = (s1_row_ff == RowLast);

      out_valid_in = out_valid_ff;
      if (s2_ready) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= RowFirst;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_row_ff    <= row_ff;
         s1_col_ff    <= s1_col_in;
         s1_prod_ff   <= s1_prod_in;
         s1_origin_ff <= pop_data.origin[row_ff];
         s1_invert_ff <= pop_data.invert;
      end
      if (s2_ready) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

FILE: design/pose_to_transform_matrix_unit.sv
// pose_to_transform_matrix_unit: quaternion pose to 3x4 homogeneous transform rows
// a pose passes front stages a, b, the queue, back stage 1 and the output register
// the back end emits one row per cycle while rsp_ready holds, rows 0 to 2 in order
// the front takes a pose every cycle until the two-entry queue and its stages fill
// reset: synchronous, clears all valid flags, queue pointers and the row counter
// uses ptm_pkg, ptm_front, ptm_queue, ptm_back
`default_nettype none

module pose_to_transform_matrix_unit import ptm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     push_valid;
   logic     push_ready;
   pose_type push_data;
   logic     pop_valid;
   logic     pop_ready;
   pose_type pop_data;

   ptm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ptm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ptm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // last flag marks exactly the third row
   a_last_on_row2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.row_index == RowLast)))
      else $error("last_row does not match row_index");

   // rows of one pose come out in order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last_row) |=>
         (!rsp_valid || rsp_data.row_index == row_type'($past(rsp_data.row_index) + 1'b1)))
      else $error("row beat out of order");

   // a new pose starts at row 0
   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_row) |=>
         (!rsp_valid || rsp_data.row_index == RowFirst))
      else $error("pose does not start at row 0");

   // the queue never refuses a push from the front while it is empty
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop_valid) |-> push_ready)
      else $error("queue refuses a push while empty");

endmodule

`default_nettype wire

FILE: bench/tb_pose_to_transform_matrix_unit.sv
`timescale 1ns / 1ps
// tb_pose_to_transform_matrix_unit: self-checking bench for the pose to transform matrix unit
// predicts the three matrix rows of every pose and compares each row beat in order
// depends on ptm_pkg and pose_to_transform_matrix_unit

module tb_pose_to_transform_matrix_unit;
   import ptm_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 20;
   localparam int RandomPoses   = 200;
   localparam int CalmPoses     = 40;

   class transform_scoreboard;
      rsp_type rows_due[$];
      int      mismatches = 0;

      task report(input string what);
         mismatches++;
         if (mismatches <= 100) $display("mismatch: %s", what);
      endtask

      // add half an lsb, then floor shift by 14
      function longint round_q14(input longint v);
         return (v + RoundHalf) >>> 14;
      endfunction

      function longint clip(input longint v, input longint lo, input longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function rot_type rot_of(input longint q28);
         return rot_type'(clip(round_q14(q28), RotMin, RotMax));
      endfunction

      function void note_pose(input req_type p);
         longint  w, x, y, z, acc, unit_q28, coord_lo, coord_hi;
         longint  org [3];
         rot_type m [3][3];
         rsp_type r;
         int      i;
         w = p.quat_w;
         x = p.quat_x;
         y = p.quat_y;
         z = p.quat_z;
         org[0] = p.origin_x;
         org[1] = p.origin_y;
         org[2] = p.origin_z;
         unit_q28 = longint'(1) <<< 28;
         coord_lo = -(longint'(1) <<< 31);
         coord_hi = (longint'(1) <<< 31) - 1;
         m[0][0] = rot_of(unit_q28 - 2 * (y * y + z * z));
         m[0][1] = rot_of(2 * (x * y - z * w));
         m[0][2] = rot_of(2 * (x * z + y * w));
         m[1][0] = rot_of(2 * (x * y + z * w));
         m[1][1] = rot_of(unit_q28 - 2 * (x * x + z * z));
         m[1][2] = rot_of(2 * (y * z - x * w));
         m[2][0] = rot_of(2 * (x * z - y * w));
         m[2][1] = rot_of(2 * (y * z + x * w));
         m[2][2] = rot_of(unit_q28 - 2 * (x * x + y * y));
         for (i = 0; i < 3; i++) begin
            r.row_index = row_type'(i);
            r.last_row  = (r.row_index == RowLast);
            if (!p.invert) begin
               r.col0        = m[i][0];
               r.col1        = m[i][1];
               r.col2        = m[i][2];
               r.translation = coord_type'(org[i]);
            end else begin
               // transposed rotation, translation from the rounded entries
               r.col0 = m[0][i];
               r.col1 = m[1][i];
               r.col2 = m[2][i];
               acc = longint'(r.col0) * org[0] + longint'(r.col1) * org[1]
                   + longint'(r.col2) * org[2];
               r.translation = coord_type'(clip(round_q14(-acc), coord_lo, coord_hi));
            end
            rows_due.push_back(r);
         end
      endfunction

      task check_row(input rsp_type got);
         rsp_type want;
         string   bad;
         if (rows_due.size() == 0) begin
            report($sformatf("row %0d beat with no pose outstanding", got.row_index));
            return;
         end
         want = rows_due.pop_front();
         bad  = "";
         if (got.row_index !== want.row_index) bad = {bad, " row_index"};
         if (got.col0 !== want.col0) bad = {bad, " col0"};
         if (got.col1 !== want.col1) bad = {bad, " col1"};
         if (got.col2 !== want.col2) bad = {bad, " col2"};
         if (got.translation !== want.translation) bad = {bad, " translation"};
         if (got.last_row !== want.last_row) bad = {bad, " last_row"};
         if (bad != "") begin
            report($sformatf("row %0d:%s got %h want %h", want.row_index, bad, got, want));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    calm = 1'b0;
   int      idle_cycles;

   transform_scoreboard sb = new;

   pose_to_transform_matrix_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic req_type make_pose(input int w, input int x, input int y,
                                         input int z, input coord_type ox,
                                         input coord_type oy, input coord_type oz,
                                         input logic inv);
      req_type p;
      p.quat_w   = rot_type'(w);
      p.quat_x   = rot_type'(x);
      p.quat_y   = rot_type'(y);
      p.quat_z   = rot_type'(z);
      p.origin_x = ox;
      p.origin_y = oy;
      p.origin_z = oz;
      p.invert   = inv;
      return p;
   endfunction

   function automatic coord_type near_origin();
      return coord_type'(int'($urandom_range(0, 2097152)) - 1048576);
   endfunction

   function automatic req_type random_pose();
      req_type p;
      real     a, b, c, d, n;
      p.quat_w   = rot_type'($urandom);
      p.quat_x   = rot_type'($urandom);
      p.quat_y   = rot_type'($urandom);
      p.quat_z   = rot_type'($urandom);
      p.origin_x = coord_type'($urandom);
      p.origin_y = coord_type'($urandom);
      p.origin_z = coord_type'($urandom);
      p.invert   = 1'($urandom_range(0, 1));
      // most poses carry a unit quaternion, the rest raw bit patterns
      if ($urandom_range(0, 9) < 7) begin
         a = p.quat_w;
         b = p.quat_x;
         c = p.quat_y;
         d = p.quat_z;
         n = $sqrt(a * a + b * b + c * c + d * d);
         if (n > 0.0) begin
            p.quat_w = rot_type'($rtoi(a / n * 16384.0));
            p.quat_x = rot_type'($rtoi(b / n * 16384.0));
            p.quat_y = rot_type'($rtoi(c / n * 16384.0));
            p.quat_z = rot_type'($rtoi(d / n * 16384.0));
         end
      end
      if ($urandom_range(0, 3) != 0) begin
         p.origin_x = near_origin();
         p.origin_y = near_origin();
         p.origin_z = near_origin();
      end
      return p;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_pose(input req_type pose);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = pose;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_pose(pose);
      @(negedge clock);
   endtask

   initial begin
      int stall;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall == 0 && !calm && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 5);
         rsp_ready = (stall == 0);
         if (stall > 0) stall--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_row(rsp_data);
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int n;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identity, straight and inverted, including origin extremes that saturate
      send_pose(make_pose(16384, 0, 0, 0, 32'h0001_0000, 32'hfffe_0000, 32'h7fff_ffff, 1'b0));
      send_pose(make_pose(16384, 0, 0, 0, 32'h0001_0000, 32'hfffe_0000, 32'h7fff_ffff, 1'b1));
      send_pose(make_pose(16384, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      send_pose(make_pose(16384, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
      send_pose(make_pose(-16384, 0, 0, 0, 32'h0000_0001, 32'hffff_ffff, 32'h0001_2345, 1'b1));
      // quarter turn about z
      send_pose(make_pose(11585, 0, 0, 11585, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          1'b0));
      send_pose(make_pose(11585, 0, 0, 11585, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          1'b1));
      // half turns about each axis
      send_pose(make_pose(0, 16384, 0, 0, 32'h0005_8000, 32'hfff0_0000, 32'h0000_4000, 1'b1));
      send_pose(make_pose(0, 0, 16384, 0, 32'h0005_8000, 32'hfff0_0000, 32'h0000_4000, 1'b0));
      send_pose(make_pose(0, 0, 0, -16384, 32'h0005_8000, 32'hfff0_0000, 32'h0000_4000, 1'b1));
      send_pose(make_pose(0, -16384, 0, 0, 32'h1234_5678, 32'h8765_4321, 32'h0000_0000, 1'b0));
      // axis permutation
      send_pose(make_pose(8192, 8192, 8192, 8192, 32'hfffb_0000, 32'h7fff_0000, 32'h0000_0003,
                          1'b1));
      // exact halves in rotation rounding, up and toward zero from below
      send_pose(make_pose(0, 1, 4096, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
      send_pose(make_pose(0, -1, 4096, 0, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0002, 1'b1));
      // non-unit quaternions driving entries, the diagonal in each pose, into the clamp
      send_pose(make_pose(32767, 32767, 32767, 32767, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 1'b1));
      send_pose(make_pose(-32768, -32768, -32768, -32768, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 1'b1));
      send_pose(make_pose(0, 32767, 32767, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                          1'b1));
      send_pose(make_pose(-32768, 32767, -32768, 32767, 32'h7fff_ffff, 32'h8000_0000,
                          32'h7fff_ffff, 1'b0));
      // all-zero and all-one bit patterns, and a zero quaternion with extreme origins
      send_pose(make_pose(0, 0, 0, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
      send_pose(make_pose(-1, -1, -1, -1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
      send_pose(make_pose(0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1));

      for (n = 0; n < RandomPoses; n++) begin
         if (n == RandomPoses - CalmPoses) calm = 1'b1;
         send_pose(random_pose());
      end
      req_valid = 1'b0;

      while (sb.rows_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
